// ----- rtl/core/vrpp_pkg.sv -----
// ----------------------------------------------------------------------------
// vrpp_pkg
// Shared types and constants of the voxel representative point picker.
// ----------------------------------------------------------------------------
package vrpp_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W = 24;
	localparam int INDEX_W = 32;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLOSEST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RANDOM  = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [INDEX_W-1:0]        cloud_index;
		logic [INDEX_W-1:0]        random_value;
		logic                      last_point;
	} vrpp_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] mean_x;
		logic signed [COORD_W-1:0] mean_y;
		logic signed [COORD_W-1:0] mean_z;
		logic [INDEX_W-1:0]        chosen_index;
		logic                      index_valid;
		logic                      overflow_flag;
	} vrpp_out_t;

endpackage

// ----- rtl/core/vrpp_ram.sv -----
// ----------------------------------------------------------------------------
// vrpp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module vrpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/vrpp_front.sv -----
// ----------------------------------------------------------------------------
// vrpp_front
// Accepts points, stores them, keeps the sums and the count, and hands a
// closed voxel to the back end through a one-deep queue.
// ----------------------------------------------------------------------------
module vrpp_front #(
	parameter int MAX_POINTS = vrpp_pkg::MAX_POINTS_DEF,
	parameter int CW = $clog2(MAX_POINTS + 1),
	parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	parameter int SW = vrpp_pkg::COORD_W + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  vrpp_pkg::vrpp_in_t    item,
	input  logic                  back_busy,
	output logic                  busy,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	// closed voxel handoff
	output logic                  job_valid,
	input  logic                  job_take,
	output logic signed [SW-1:0]  job_sx,
	output logic signed [SW-1:0]  job_sy,
	output logic signed [SW-1:0]  job_sz,
	output logic [CW-1:0]         job_cnt,
	output logic [vrpp_pkg::INDEX_W-1:0] job_rnd,
	output logic                  job_drop
);
	import vrpp_pkg::*;

	logic [CW-1:0]        cnt_q;
	logic signed [SW-1:0] sx_q, sy_q, sz_q;
	logic                 drop_q;
	logic                 acc, full;

	// hold while a closed voxel waits or the back end still reads the point store
	assign busy = job_valid || back_busy;
	assign acc = start && !busy;
	assign full = (cnt_q == CW'(MAX_POINTS));
	assign we = acc && !full;
	assign waddr = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
			drop_q <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			if (job_take) begin
				job_valid <= 1'b0;
			end
			if (acc) begin
				if (item.last_point) begin
					job_valid <= 1'b1;
					job_sx <= full ? sx_q : sx_q + SW'(item.coord_x);
					job_sy <= full ? sy_q : sy_q + SW'(item.coord_y);
					job_sz <= full ? sz_q : sz_q + SW'(item.coord_z);
					job_cnt <= full ? cnt_q : cnt_q + 1'b1;
					job_drop <= drop_q || full;
					job_rnd <= item.random_value;
					cnt_q <= '0;
					sx_q <= '0;
					sy_q <= '0;
					sz_q <= '0;
					drop_q <= 1'b0;
				end else if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					sx_q <= sx_q + SW'(item.coord_x);
					sy_q <= sy_q + SW'(item.coord_y);
					sz_q <= sz_q + SW'(item.coord_z);
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("count past depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> job_cnt != '0)
		else $error("empty voxel handed off");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.last_point |=> job_valid && cnt_q == '0)
		else $error("voxel not closed");
endmodule

// ----- rtl/core/vrpp_back.sv -----
// ----------------------------------------------------------------------------
// vrpp_back
// Divides the sums by the count, then picks a point by walking the store
// (closest mode) or by one lookup after a modulo (random mode).
// ----------------------------------------------------------------------------
module vrpp_back #(
	parameter int MAX_POINTS = vrpp_pkg::MAX_POINTS_DEF,
	parameter int CW = $clog2(MAX_POINTS + 1),
	parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	parameter int SW = vrpp_pkg::COORD_W + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [vrpp_pkg::MODE_W-1:0] mode,
	input  logic                  job_valid,
	output logic                  job_take,
	input  logic signed [SW-1:0]  job_sx,
	input  logic signed [SW-1:0]  job_sy,
	input  logic signed [SW-1:0]  job_sz,
	input  logic [CW-1:0]         job_cnt,
	input  logic [vrpp_pkg::INDEX_W-1:0] job_rnd,
	input  logic                  job_drop,
	output logic [AW-1:0]         raddr,
	input  logic signed [vrpp_pkg::COORD_W-1:0] rd_x,
	input  logic signed [vrpp_pkg::COORD_W-1:0] rd_y,
	input  logic signed [vrpp_pkg::COORD_W-1:0] rd_z,
	input  logic [vrpp_pkg::INDEX_W-1:0]        rd_idx,
	output logic                  idle,
	output logic                  done,
	output vrpp_pkg::vrpp_out_t   result
);
	import vrpp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_WALK = 3'd3;
	localparam logic [2:0] ST_RAND = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam int DW = SW - 1;
	localparam int DBW = $clog2(DW + 1);
	localparam int EW = 2 * (COORD_W + 2) + 2;

	logic [2:0] st_q;
	logic [MODE_W-1:0] mode_q;
	logic [CW-1:0] cnt_q;
	logic [INDEX_W-1:0] rnd_q;
	logic drop_q;
	// restoring division, all three axes in parallel
	logic [DW-1:0] qx_q, qy_q, qz_q;
	logic [CW-1:0] rx_q, ry_q, rz_q, rm_q;
	logic nx_q, ny_q, nz_q;
	logic [DBW-1:0] bit_q;
	logic [5:0] mbit_q;
	logic signed [COORD_W-1:0] mx_q, my_q, mz_q;
	// walk
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] seen_q;
	logic [EW-1:0] best_q;
	logic [INDEX_W-1:0] chosen_q;
	logic signed [COORD_W:0] dx, dy, dz;
	logic [EW-1:0] e;
	logic [CW:0] tx, ty, tz, tm;

	function automatic logic [DW-1:0] mag(input logic signed [SW-1:0] v);
		logic [SW-1:0] a;
		a = v[SW-1] ? SW'(-v) : SW'(v);
		return a[DW-1:0];
	endfunction

	assign tx = {rx_q, qx_q[DW-1]};
	assign ty = {ry_q, qy_q[DW-1]};
	assign tz = {rz_q, qz_q[DW-1]};
	assign tm = {rm_q, rnd_q[INDEX_W-1]};

	assign dx = (COORD_W+1)'(rd_x) - (COORD_W+1)'(mx_q);
	assign dy = (COORD_W+1)'(rd_y) - (COORD_W+1)'(my_q);
	assign dz = (COORD_W+1)'(rd_z) - (COORD_W+1)'(mz_q);
	assign e = EW'(dx * dx) + EW'(dy * dy) + EW'(dz * dz);

	assign job_take = (st_q == ST_IDLE) && job_valid;
	assign idle = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						mode_q <= mode;
						cnt_q <= job_cnt;
						rnd_q <= job_rnd;
						drop_q <= job_drop;
						qx_q <= mag(job_sx);
						qy_q <= mag(job_sy);
						qz_q <= mag(job_sz);
						nx_q <= job_sx[SW-1];
						ny_q <= job_sy[SW-1];
						nz_q <= job_sz[SW-1];
						rx_q <= '0;
						ry_q <= '0;
						rz_q <= '0;
						rm_q <= '0;
						bit_q <= DBW'(DW);
						mbit_q <= 6'd32;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rx_q <= (tx >= {1'b0, cnt_q}) ? CW'(tx - {1'b0, cnt_q}) : tx[CW-1:0];
					ry_q <= (ty >= {1'b0, cnt_q}) ? CW'(ty - {1'b0, cnt_q}) : ty[CW-1:0];
					rz_q <= (tz >= {1'b0, cnt_q}) ? CW'(tz - {1'b0, cnt_q}) : tz[CW-1:0];
					qx_q <= {qx_q[DW-2:0], tx >= {1'b0, cnt_q}};
					qy_q <= {qy_q[DW-2:0], ty >= {1'b0, cnt_q}};
					qz_q <= {qz_q[DW-2:0], tz >= {1'b0, cnt_q}};
					bit_q <= bit_q - 1'b1;
					if (bit_q == DBW'(1)) begin
						st_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mbit_q == 6'd0) begin
						mx_q <= nx_q ? COORD_W'(-qx_q) : COORD_W'(qx_q);
						my_q <= ny_q ? COORD_W'(-qy_q) : COORD_W'(qy_q);
						mz_q <= nz_q ? COORD_W'(-qz_q) : COORD_W'(qz_q);
						ptr_q <= '0;
						seen_q <= '0;
						chosen_q <= '0;
						if (mode_q == MODE_CLOSEST) begin
							st_q <= ST_WALK;
						end else if (mode_q == MODE_RANDOM) begin
							ptr_q <= rm_q;
							st_q <= ST_RAND;
						end else begin
							st_q <= ST_OUT;
						end
					end else begin
						rm_q <= (tm >= {1'b0, cnt_q}) ? CW'(tm - {1'b0, cnt_q}) : tm[CW-1:0];
						rnd_q <= {rnd_q[INDEX_W-2:0], 1'b0};
						mbit_q <= mbit_q - 1'b1;
					end
				end
				ST_WALK: begin
					if (ptr_q != cnt_q) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (ptr_q != '0) begin
						seen_q <= seen_q + 1'b1;
						if (seen_q == '0 || e < best_q) begin
							best_q <= e;
							chosen_q <= rd_idx;
						end
						if (seen_q + 1'b1 == cnt_q) begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_RAND: begin
					seen_q <= seen_q + 1'b1;
					if (seen_q != '0) begin
						chosen_q <= rd_idx;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					result.mean_x <= mx_q;
					result.mean_y <= my_q;
					result.mean_z <= mz_q;
					result.chosen_index <= chosen_q;
					result.index_valid <= (mode_q == MODE_CLOSEST) || (mode_q == MODE_RANDOM);
					result.overflow_flag <= drop_q;
					done <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign raddr = ptr_q[AW-1:0];

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == ST_OUT)
		else $error("result without output step");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WALK |-> seen_q < cnt_q)
		else $error("walk past count");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RAND |-> rm_q < cnt_q)
		else $error("random pick out of range");
endmodule

// ----- rtl/core/voxel_representative_point_picker_core.sv -----
// ----------------------------------------------------------------------------
// voxel_representative_point_picker_core
// Picks one representative point per voxel: mean, closest to mean, or random.
// ----------------------------------------------------------------------------
// A point is taken on start while busy is low. The item marked last_point
// closes the voxel; the closed voxel moves to the back end and busy stays
// high until the result appears, since the back end reads the point store
// the next voxel would overwrite. The back end takes the voxel, runs the
// restoring divider (all three means at once), then the modulo of the
// random value by the count, then walks the point store in closest mode
// (one store read per cycle) or reads one stored point in random mode,
// and then presents the result. The result shows for one cycle with done
// high; the receiver cannot stall it.
module voxel_representative_point_picker_core #(
	parameter int MAX_POINTS = vrpp_pkg::MAX_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  vrpp_pkg::vrpp_in_t   item,
	output logic                 busy,
	output logic                 done,
	output vrpp_pkg::vrpp_out_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [vrpp_pkg::MODE_W-1:0] cfg_data
);
	import vrpp_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SW = COORD_W + CW;

	logic [MODE_W-1:0] mode_q;
	logic we, job_valid, job_take, bidle;
	logic [AW-1:0] waddr, raddr;
	logic signed [SW-1:0] sx, sy, sz;
	logic [CW-1:0] jcnt;
	logic [INDEX_W-1:0] jrnd;
	logic jdrop;
	logic signed [COORD_W-1:0] rx, ry, rz;
	logic [INDEX_W-1:0] ridx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_AVERAGE;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	vrpp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk, .arst_n, .start, .item, .back_busy(!bidle), .busy, .we, .waddr,
		.job_valid, .job_take, .job_sx(sx), .job_sy(sy), .job_sz(sz),
		.job_cnt(jcnt), .job_rnd(jrnd), .job_drop(jdrop)
	);

	vrpp_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk, .we, .waddr, .wdata(item.coord_x), .raddr, .rdata(rx));
	vrpp_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk, .we, .waddr, .wdata(item.coord_y), .raddr, .rdata(ry));
	vrpp_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_z (
		.clk, .we, .waddr, .wdata(item.coord_z), .raddr, .rdata(rz));
	vrpp_ram #(.WIDTH(INDEX_W), .DEPTH(MAX_POINTS)) u_ram_i (
		.clk, .we, .waddr, .wdata(item.cloud_index), .raddr, .rdata(ridx));

	vrpp_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk, .arst_n, .mode(mode_q), .job_valid, .job_take,
		.job_sx(sx), .job_sy(sy), .job_sz(sz), .job_cnt(jcnt), .job_rnd(jrnd),
		.job_drop(jdrop), .raddr, .rd_x(rx), .rd_y(ry), .rd_z(rz), .rd_idx(ridx),
		.idle(bidle), .done, .result
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !bidle || !$past(bidle))
		else $error("result while back end idle");
endmodule
